### sv/assert_macros.svh
// Assertion macros shared by the motor starter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk_i outside reset.
`define MSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every rising edge of clk_i, reset included.
`define MSS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/mss_pkg.sv
// Types, register map and reset values of the motor starter sequencer.
`timescale 1ns / 1ps
package mss_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned UnitW  = 3;
  localparam int unsigned BlinkW = 6;
  localparam int unsigned TryW   = 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned InW    = 8;
  localparam int unsigned OutW   = 8;

  // Sequence steps, one-hot
  typedef enum logic [10:0] {
    ST_IDLE      = 11'h001,
    ST_WAIT_A    = 11'h002,
    ST_WAIT_B    = 11'h004,
    ST_H3_STOP   = 11'h008,
    ST_H3_START  = 11'h010,
    ST_COND_TRY  = 11'h020,
    ST_COND_HOLD = 11'h040,
    ST_H2_STOP   = 11'h080,
    ST_H2_START  = 11'h100,
    ST_ERROR     = 11'h200,
    ST_STOPPING  = 11'h400
  } step_e;

  // Register indexes (byte address bits [4:2])
  typedef enum logic [2:0] {
    REG_BLINK_HALF = 3'd0,
    REG_WAIT_BLINK = 3'd1,
    REG_LONG_UNIT  = 3'd2,
    REG_STOP_HOLD  = 3'd3,
    REG_COND_TRIES = 3'd4
  } reg_e;

  // Hold lengths in long units
  localparam logic [UnitW-1:0] HOLD_ONE   = 3'd1;
  localparam logic [UnitW-1:0] HOLD_THREE = 3'd3;
  localparam logic [UnitW-1:0] HOLD_FIVE  = 3'd5;

  typedef struct packed {
    logic stop_rly;
    logic start_rly;
    logic cap_rly;
    logic wait_lamp;
    logic warn_led;
  } outs_t;

  typedef struct packed {
    step_e              step;
    logic [TickW-1:0]   tick;
    logic [UnitW-1:0]   unit;
    logic [BlinkW-1:0]  blink;
    logic [TryW-1:0]    tries;
    logic               running;
    logic               two_phase;
    outs_t              outs;
  } state_t;

  typedef struct packed {
    logic [TickW-1:0]  blink_half;
    logic [BlinkW-1:0] wait_blink;
    logic [TickW-1:0]  long_unit;
    logic [TickW-1:0]  stop_hold;
    logic [TryW-1:0]   cond_tries;
  } cfg_t;

  typedef struct packed {
    logic condenser_ok;
    logic third_phase_ok;
    logic stop_phase_ok;
    logic auto_mode;
    logic stop_button;
    logic start_button;
  } tick_in_t;

  localparam cfg_t CFG_RESET = '{
    blink_half: 16'd500,
    wait_blink: 6'd31,
    long_unit:  16'd1001,
    stop_hold:  16'd2500,
    cond_tries: 4'd6
  };

  localparam state_t STATE_RESET = '{
    step:      ST_IDLE,
    tick:      '0,
    unit:      '0,
    blink:     '0,
    tries:     '0,
    running:   1'b0,
    two_phase: 1'b0,
    outs:      '0
  };

endpackage

### sv/mss_step.sv
// Next-state logic of the motor starter sequencer for one tick.
`timescale 1ns / 1ps
module mss_step (
  input  mss_pkg::state_t   state_i,
  input  mss_pkg::cfg_t     cfg_i,
  input  mss_pkg::tick_in_t in_i,
  output mss_pkg::state_t   state_o
);
  import mss_pkg::*;

  logic [TickW-1:0]  tick_inc;
  logic [UnitW-1:0]  unit_inc;
  logic [BlinkW-1:0] blink_inc;
  logic [TryW-1:0]   try_inc;
  logic [UnitW-1:0]  hold_units;
  logic              unit_wrap;
  logic              hold_done;
  logic              blink_wrap;
  logic              led_lit;
  logic              half_done;

  assign tick_inc  = state_i.tick + 1'b1;
  assign unit_inc  = state_i.unit + 1'b1;
  assign blink_inc = state_i.blink + 1'b1;
  assign try_inc   = state_i.tries + 1'b1;

  // Hold length of the current step
  always_comb begin
    case (state_i.step)
      ST_H3_STOP:   hold_units = HOLD_THREE;
      ST_H2_START:  hold_units = HOLD_THREE;
      ST_COND_HOLD: hold_units = HOLD_FIVE;
      default:      hold_units = HOLD_ONE;
    endcase
  end

  assign unit_wrap  = tick_inc >= cfg_i.long_unit;
  assign hold_done  = unit_wrap && !(unit_inc < hold_units);
  assign blink_wrap = tick_inc >= cfg_i.blink_half;
  assign led_lit    = (state_i.step == ST_ERROR) ? state_i.outs.warn_led
                                                 : state_i.outs.wait_lamp;
  assign half_done  = blink_wrap && !led_lit;

  always_comb begin
    state_o = state_i;
    // Shared hold timer: advance ticks, then units
    if (state_i.step == ST_H3_STOP || state_i.step == ST_H3_START ||
        state_i.step == ST_COND_HOLD || state_i.step == ST_H2_STOP ||
        state_i.step == ST_H2_START) begin
      if (!unit_wrap) begin
        state_o.tick = tick_inc;
      end else begin
        state_o.tick = '0;
        state_o.unit = hold_done ? '0 : unit_inc;
      end
    end
    // Shared blink timer: a lit half ending just darkens the LED
    if (state_i.step == ST_WAIT_A || state_i.step == ST_WAIT_B ||
        state_i.step == ST_ERROR) begin
      if (!blink_wrap) begin
        state_o.tick = tick_inc;
      end else begin
        state_o.tick = '0;
        if (state_i.step == ST_ERROR) begin
          state_o.outs.warn_led = 1'b0;
        end else begin
          state_o.outs.wait_lamp = 1'b0;
        end
      end
    end

    case (state_i.step)
      ST_IDLE: begin
        if (!state_i.running) begin
          if (in_i.auto_mode || in_i.start_button) begin
            state_o.two_phase      = !in_i.third_phase_ok;
            state_o.step           = ST_WAIT_A;
            state_o.tick           = '0;
            state_o.blink          = '0;
            state_o.outs.wait_lamp = 1'b1;
          end
        end else if ((!in_i.auto_mode && in_i.stop_button) || !in_i.stop_phase_ok) begin
          state_o.outs.stop_rly  = 1'b0;
          state_o.outs.start_rly = 1'b0;
          state_o.outs.wait_lamp = 1'b1;
          state_o.step           = ST_STOPPING;
          state_o.tick           = '0;
        end
      end
      ST_WAIT_A, ST_WAIT_B: begin
        if (half_done) begin
          if (blink_inc < cfg_i.wait_blink) begin
            state_o.blink          = blink_inc;
            state_o.outs.wait_lamp = 1'b1;
          end else begin
            state_o.blink = '0;
            if (state_i.step == ST_WAIT_B) begin
              state_o.outs.stop_rly = 1'b1;
              state_o.step          = ST_H3_STOP;
              state_o.unit          = '0;
            end else if (state_i.two_phase) begin
              if (!in_i.stop_phase_ok) begin
                state_o.step          = ST_ERROR;
                state_o.outs.warn_led = 1'b1;
              end else begin
                state_o.tries = '0;
                state_o.step  = ST_COND_TRY;
              end
            end else if (!in_i.stop_phase_ok || !in_i.third_phase_ok) begin
              state_o.step          = ST_ERROR;
              state_o.outs.warn_led = 1'b1;
            end else begin
              state_o.step           = ST_WAIT_B;
              state_o.outs.wait_lamp = 1'b1;
            end
          end
        end
      end
      ST_H3_STOP: begin
        if (hold_done) begin
          state_o.outs.start_rly = 1'b1;
          state_o.step           = ST_H3_START;
        end
      end
      ST_H3_START: begin
        if (hold_done) begin
          state_o.outs.start_rly = 1'b0;
          state_o.running        = 1'b1;
          state_o.step           = ST_IDLE;
        end
      end
      ST_COND_TRY: begin
        state_o.tick = '0;
        state_o.unit = '0;
        if (in_i.condenser_ok) begin
          state_o.outs.start_rly = 1'b1;
          state_o.outs.stop_rly  = 1'b1;
          state_o.step           = ST_H2_STOP;
        end else begin
          state_o.outs.start_rly = 1'b0;
          state_o.tries          = try_inc;
          state_o.step           = ST_COND_HOLD;
        end
      end
      ST_COND_HOLD: begin
        if (hold_done) begin
          if (state_i.tries < cfg_i.cond_tries) begin
            state_o.step = ST_COND_TRY;
          end else if (in_i.condenser_ok) begin
            state_o.outs.stop_rly = 1'b1;
            state_o.step          = ST_H2_STOP;
          end else begin
            state_o.step          = ST_ERROR;
            state_o.tick          = '0;
            state_o.outs.warn_led = 1'b1;
          end
        end
      end
      ST_H2_STOP: begin
        if (hold_done) begin
          state_o.outs.start_rly = 1'b1;
          state_o.outs.cap_rly   = 1'b1;
          state_o.step           = ST_H2_START;
        end
      end
      ST_H2_START: begin
        if (hold_done) begin
          state_o.outs.start_rly = 1'b0;
          state_o.outs.cap_rly   = 1'b0;
          state_o.running        = 1'b1;
          state_o.step           = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (half_done) begin
          if (in_i.stop_button) begin
            state_o.step = ST_IDLE;
          end else begin
            state_o.outs.warn_led = 1'b1;
          end
        end
      end
      ST_STOPPING: begin
        if (tick_inc >= cfg_i.stop_hold) begin
          state_o.tick           = '0;
          state_o.running        = 1'b0;
          state_o.outs.wait_lamp = 1'b0;
          state_o.step           = ST_IDLE;
        end else begin
          state_o.tick = tick_inc;
        end
      end
      default: begin
        state_o.step = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/motor_starter_sequencer_top.sv
// Top level of the motor starter sequencer: stream ports, register file, state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Motor starter sequencer. Each transfer on the input stream is one timebase
// tick carrying the sampled button and phase pins; each tick produces exactly
// one result transfer with the relay and LED states after that tick. The block
// takes one tick per clock cycle unless the result stream stalls: the whole
// sequence update is one pass of logic between the state register and the
// output register. The output register doubles as a skid stage: a new tick is
// taken whenever the output is empty or its result is being taken in the same
// cycle. The five timing registers sit on the APB port at byte addresses 0, 4,
// 8, 12 and 16; the user must write them only while the stream is quiet, which
// the block does not enforce. Accesses elsewhere are ignored and read as zero.
module motor_starter_sequencer_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Tick stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [0] start_button, [1] stop_button, [2] auto_mode, [3] stop_phase_ok,
  // [4] third_phase_ok, [5] condenser_ok, [7:6] zero
  input  logic [mss_pkg::InW-1:0]   s_axis_tdata,
  // Result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [0] stop_relay_closed, [1] start_relay_closed, [2] start_cap_relay_closed,
  // [3] wait_lamp_on, [4] warning_led_on, [5] motor_running, [6] busy_res,
  // [7] zero
  output logic [mss_pkg::OutW-1:0]  m_axis_tdata,
  // Register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mss_pkg::AddrW-1:0] paddr,
  input  logic [mss_pkg::DataW-1:0] pwdata,
  output logic [mss_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import mss_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  tick_in_t          tick_in;
  logic              in_xfer;
  logic              cfg_wr;
  reg_e              reg_sel;
  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q, out_data_d;
  logic              any_rly_closed;
  logic              start_side_closed;

  // ---------------------------------------------------------------------------
  // Register port: pready always high, write on the access cycle
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_BLINK_HALF: cfg_q.blink_half <= pwdata[TickW-1:0];
        REG_WAIT_BLINK: cfg_q.wait_blink <= pwdata[BlinkW-1:0];
        REG_LONG_UNIT:  cfg_q.long_unit  <= pwdata[TickW-1:0];
        REG_STOP_HOLD:  cfg_q.stop_hold  <= pwdata[TickW-1:0];
        REG_COND_TRIES: cfg_q.cond_tries <= pwdata[TryW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BLINK_HALF: prdata = DataW'(cfg_q.blink_half);
      REG_WAIT_BLINK: prdata = DataW'(cfg_q.wait_blink);
      REG_LONG_UNIT:  prdata = DataW'(cfg_q.long_unit);
      REG_STOP_HOLD:  prdata = DataW'(cfg_q.stop_hold);
      REG_COND_TRIES: prdata = DataW'(cfg_q.cond_tries);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tick transfer: take a tick whenever the output slot is free or draining
  // ---------------------------------------------------------------------------
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign tick_in.start_button   = s_axis_tdata[0];
  assign tick_in.stop_button    = s_axis_tdata[1];
  assign tick_in.auto_mode      = s_axis_tdata[2];
  assign tick_in.stop_phase_ok  = s_axis_tdata[3];
  assign tick_in.third_phase_ok = s_axis_tdata[4];
  assign tick_in.condenser_ok   = s_axis_tdata[5];

  mss_step u_step (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .in_i    (tick_in),
    .state_o (state_d)
  );

  // Advance the sequence only on a tick transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Pack the result from the updated state
  assign out_data_d = {1'b0,
                       state_d.step != ST_IDLE,
                       state_d.running,
                       state_d.outs.warn_led,
                       state_d.outs.wait_lamp,
                       state_d.outs.cap_rly,
                       state_d.outs.start_rly,
                       state_d.outs.stop_rly};

  // Output register: load on a tick transfer, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  assign any_rly_closed    = state_q.outs.stop_rly || state_q.outs.start_rly ||
                             state_q.outs.cap_rly;
  assign start_side_closed = state_q.outs.start_rly || state_q.outs.cap_rly;

  // The sequence state moves only on a tick transfer
  `MSS_ASSERT(a_state_holds, !in_xfer |=> $stable(state_q), "state moved without a tick")
  // The warning LED only blinks with every relay open
  `MSS_ASSERT_ALWAYS(a_warn_relays_open, state_q.outs.warn_led |-> !any_rly_closed, "relay closed")
  // A running motor never keeps the start or condenser relay closed
  `MSS_ASSERT_ALWAYS(a_run_start_open, state_q.running |-> !start_side_closed, "start relay closed")

endmodule
